>>> rtl/epd_pkg.sv
package epd_pkg;

  localparam int MUL_W = 36;

  typedef logic signed [MUL_W-1:0]   mop_t;
  typedef logic signed [2*MUL_W-1:0] mprod_t;

  // Handshake status of an iterative unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_RADIUS_X = 3'd2;
  localparam logic [2:0] REG_RADIUS_Y = 3'd3;
  localparam logic [2:0] REG_COS_ROT  = 3'd4;
  localparam logic [2:0] REG_SIN_ROT  = 3'd5;

  localparam logic signed [31:0] ONE_Q30    = 32'sh40000000;
  localparam logic signed [31:0] NEG_ONE_Q30 = -32'sh40000000;
  localparam logic signed [63:0] S32_MAX    = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN    = -64'sd2147483648;

  // Shift right by 30, rounding to nearest with ties away from zero.
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
    logic [63:0] m;
    logic        neg;
    neg = v[63];
    m   = neg ? 64'(-v) : 64'(v);
    m   = (m + 64'h20000000) >> 30;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // Drop three bits, truncating toward zero.
  function automatic logic signed [35:0] trunc3(input logic signed [35:0] v);
    logic [35:0] m;
    logic        neg;
    neg = v[35];
    m   = neg ? 36'(-v) : 36'(v);
    m   = m >> 3;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = -32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_rot(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) begin
      r = ONE_Q30;
    end else if (v < NEG_ONE_Q30) begin
      r = NEG_ONE_Q30;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Sine or cosine of a Q0.32 turn in Q2.30, by octant folding and a
  // seven-term series. Only evaluated on constants to build the sample table.
  function automatic logic signed [31:0] trig_val(input logic [31:0] a,
                                                  input logic want_cos);
    longint     r, x, x2, ts, tc, ss, cc, ks, kc, rs, rc;
    logic       swap;
    logic [1:0] q;
    q    = a[31:30];
    r    = longint'(a[29:0]);
    swap = r > 64'sh20000000;
    if (swap) r = 64'sh40000000 - r;
    x  = (r * 64'sd3373259426) >>> 31;
    x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
    ts = x;
    tc = 64'sd1 <<< 30;
    ss = ts;
    cc = tc;
    ts = ((ts * x2) >>> 30) / 6;   tc = ((tc * x2) >>> 30) / 2;   ss -= ts; cc -= tc;
    ts = ((ts * x2) >>> 30) / 20;  tc = ((tc * x2) >>> 30) / 12;  ss += ts; cc += tc;
    ts = ((ts * x2) >>> 30) / 42;  tc = ((tc * x2) >>> 30) / 30;  ss -= ts; cc -= tc;
    ts = ((ts * x2) >>> 30) / 72;  tc = ((tc * x2) >>> 30) / 56;  ss += ts; cc += tc;
    ts = ((ts * x2) >>> 30) / 110; tc = ((tc * x2) >>> 30) / 90;  ss -= ts; cc -= tc;
    ts = ((ts * x2) >>> 30) / 156; tc = ((tc * x2) >>> 30) / 132; ss += ts; cc += tc;
    if (swap) begin
      ks = cc; kc = ss;
    end else begin
      ks = ss; kc = cc;
    end
    case (q)
      2'd0:    begin rc = kc;  rs = ks;  end
      2'd1:    begin rc = -ks; rs = kc;  end
      2'd2:    begin rc = -kc; rs = -ks; end
      default: begin rc = ks;  rs = -kc; end
    endcase
    return want_cos ? 32'(rc) : 32'(rs);
  endfunction

endpackage

>>> rtl/epd_mul.sv
module epd_mul
  import epd_pkg::*;
(
  input  logic   clk,
  input  mop_t   a,
  input  mop_t   b,
  output mprod_t p
);

  mprod_t p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

>>> rtl/epd_div.sv
module epd_div
  import epd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [59:0] num,
  input  logic [59:0] den,
  output logic [29:0] quo,
  output unit_sts_t   sts
);

  // Restoring division of num < den, one quotient bit a cycle.
  logic [60:0] rem_r;
  logic [59:0] den_r;
  logic [29:0] quo_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [60:0] rem_sh;

  assign rem_sh = {rem_r[59:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= {1'b0, num};
        den_r  <= den;
        quo_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= rem_sh - {1'b0, den_r};
          quo_r <= {quo_r[28:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[28:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd29) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo      = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

>>> rtl/epd_sqrt.sv
module epd_sqrt
  import epd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] rad,
  output logic [31:0] root,
  output unit_sts_t   sts
);

  // Digit-by-digit square root, one result bit a cycle, then rounding.
  logic [63:0] n_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] trial;
  logic [63:0] rounded;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r    <= rad;
        res_r  <= '0;
        bit_r  <= 64'h4000000000000000;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (n_r >= trial) begin
          n_r   <= n_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rounded  = (n_r > res_r) ? res_r + 64'd1 : res_r;
  assign root     = (rounded > 64'hFFFFFFFF) ? 32'hFFFFFFFF : rounded[31:0];
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

>>> rtl/ellipse_polygon_point_distance_unit.sv
// Channel   Direction  Handshake             Payload
// in_       slave      in_tvalid/in_tready   in_tdata: point_x, point_y
// out_      master     out_tvalid/out_tready out_tdata: distance
// cfg_      write      cfg_we                cfg_addr, cfg_wdata
//
// A query works through every vertex and edge in turn. Each vertex and edge
// uses the single shared multiplier, used once a cycle; edges also use the
// bit-serial divider and the square root; edges that skip either are shorter.
// Reset is synchronous and active low; it restores the register defaults.
// in_tready is high only while no query is in progress. A finished result
// waits in the output register; a new query is taken meanwhile, and the
// block holds its next result until the output register is free.
module ellipse_polygon_point_distance_unit
  import epd_pkg::*;
#(
  parameter int SAMPLES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] point_x, [63:32] point_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] distance
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int IW = $clog2(SAMPLES);
  localparam int CW = $clog2(SAMPLES + 1);
  localparam logic [CW-1:0] IDX_LAST = CW'(SAMPLES - 1);
  localparam logic [CW-1:0] IDX_END  = CW'(SAMPLES);

  // Vertex states (V*), edge setup (E*), projection (P*), distance (D*).
  typedef enum logic [23:0] {
    S_IDLE = 24'h000001, S_V0  = 24'h000002, S_V1  = 24'h000004,
    S_V2   = 24'h000008, S_V3  = 24'h000010, S_V4  = 24'h000020,
    S_V5   = 24'h000040, S_V6  = 24'h000080, S_E0  = 24'h000100,
    S_E1   = 24'h000200, S_E2  = 24'h000400, S_E3  = 24'h000800,
    S_E4   = 24'h001000, S_E5  = 24'h002000, S_DIV = 24'h004000,
    S_P0   = 24'h008000, S_P1  = 24'h010000, S_P2  = 24'h020000,
    S_D0   = 24'h040000, S_D1  = 24'h080000, S_D2  = 24'h100000,
    S_SQ   = 24'h200000, S_CMP = 24'h400000, S_FIN = 24'h800000
  } state_t;

  state_t state_r, state_nxt;

  // Sample table of the unit circle, built at elaboration.
  logic signed [31:0] tab_cos [SAMPLES];
  logic signed [31:0] tab_sin [SAMPLES];

  for (genvar g = 0; g < SAMPLES; g++) begin : g_tab
    localparam logic [31:0] ANG = 32'((64'(g) << 32) / SAMPLES);
    assign tab_cos[g] = trig_val(ANG, 1'b1);
    assign tab_sin[g] = trig_val(ANG, 1'b0);
  end

  // Configuration registers.
  logic signed [31:0] center_x_r, center_y_r, cos_rot_r, sin_rot_r;
  logic [30:0]        radius_x_r, radius_y_r;

  // Working registers.
  logic signed [31:0] px_r, py_r, ax_r, ay_r, bx_r, by_r, fx_r, fy_r;
  logic signed [32:0] lx_r, ly_r;
  logic signed [63:0] acc_r, len_r;
  logic signed [35:0] sx_r, sy_r, sxs_r, sys_r, dxs_r, dys_r, ex_r, ey_r;
  logic [30:0]        t_r;
  logic [31:0]        d_r, best_r, out_data_r;
  logic [CW-1:0]      idx_r;
  logic               out_valid_r;

  mop_t   mul_a, mul_b;
  mprod_t mul_p;
  logic signed [63:0] p64;
  logic signed [31:0] c_cl, s_cl;
  logic signed [35:0] sx_w, sy_w, dx_w, dy_w;
  logic signed [63:0] dot_w, projx_w, projy_w, ex_w, ey_w;
  logic [64:0]        sum_w;
  logic               div_start, sqrt_start;
  logic               len_zero, dot_full, dot_pos;
  logic [29:0]        quo;
  logic [31:0]        root;
  unit_sts_t          div_sts, sqrt_sts;
  logic               in_xfer;

  assign c_cl = clamp_rot(cos_rot_r);
  assign s_cl = clamp_rot(sin_rot_r);
  assign p64  = $signed(mul_p[63:0]);

  assign sx_w = 36'(bx_r) - 36'(ax_r);
  assign sy_w = 36'(by_r) - 36'(ay_r);
  assign dx_w = 36'(px_r) - 36'(ax_r);
  assign dy_w = 36'(py_r) - 36'(ay_r);

  assign dot_w    = acc_r + p64;
  assign len_zero = (len_r == 64'sd0);
  assign dot_full = (dot_w >= len_r);
  assign dot_pos  = (dot_w > 64'sd0);

  assign projx_w = 64'(ax_r) + rnd30(p64);
  assign projy_w = 64'(ay_r) + rnd30(p64);
  assign ex_w    = 64'(px_r) - projx_w;
  assign ey_w    = 64'(py_r) - projy_w;

  // Squared magnitudes wrap modulo 2^64; a carry out marks overflow.
  assign sum_w = {1'b0, acc_r[63:0]} + {1'b0, mul_p[63:0]};

  assign div_start  = (state_r == S_E5) && !len_zero && !dot_full && dot_pos;
  assign sqrt_start = (state_r == S_D2) && !sum_w[64];

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_V0:    begin mul_a = $signed({5'b0, radius_x_r}); mul_b = 36'(tab_cos[idx_r[IW-1:0]]); end
      S_V1:    begin mul_a = $signed({5'b0, radius_y_r}); mul_b = 36'(tab_sin[idx_r[IW-1:0]]); end
      S_V2:    begin mul_a = 36'(lx_r); mul_b = 36'(c_cl); end
      S_V3:    begin mul_a = 36'(ly_r); mul_b = 36'(s_cl); end
      S_V4:    begin mul_a = 36'(lx_r); mul_b = 36'(s_cl); end
      S_V5:    begin mul_a = 36'(ly_r); mul_b = 36'(c_cl); end
      S_E1:    begin mul_a = sxs_r; mul_b = sxs_r; end
      S_E2:    begin mul_a = sys_r; mul_b = sys_r; end
      S_E3:    begin mul_a = dxs_r; mul_b = sxs_r; end
      S_E4:    begin mul_a = dys_r; mul_b = sys_r; end
      S_P0:    begin mul_a = sx_r; mul_b = $signed({5'b0, t_r}); end
      S_P1:    begin mul_a = sy_r; mul_b = $signed({5'b0, t_r}); end
      S_D0:    begin
        mul_a = ex_r[35] ? -ex_r : ex_r;
        mul_b = ex_r[35] ? -ex_r : ex_r;
      end
      S_D1:    begin
        mul_a = ey_r[35] ? -ey_r : ey_r;
        mul_b = ey_r[35] ? -ey_r : ey_r;
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  epd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  epd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (dot_w[59:0]),
    .den   (len_r[59:0]),
    .quo   (quo),
    .sts   (div_sts)
  );

  epd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (sum_w[63:0]),
    .root  (root),
    .sts   (sqrt_sts)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_V0;
      S_V0:   state_nxt = S_V1;
      S_V1:   state_nxt = S_V2;
      S_V2:   state_nxt = S_V3;
      S_V3:   state_nxt = S_V4;
      S_V4:   state_nxt = S_V5;
      S_V5:   state_nxt = S_V6;
      S_V6:   state_nxt = (idx_r == '0) ? S_V0 : S_E0;
      S_E0:   state_nxt = S_E1;
      S_E1:   state_nxt = S_E2;
      S_E2:   state_nxt = S_E3;
      S_E3:   state_nxt = S_E4;
      S_E4:   state_nxt = S_E5;
      S_E5: begin
        if (len_zero) begin
          state_nxt = S_D0;
        end else if (div_start) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_P0;
        end
      end
      S_DIV:  if (div_sts.done) state_nxt = S_P0;
      S_P0:   state_nxt = S_P1;
      S_P1:   state_nxt = S_P2;
      S_P2:   state_nxt = S_D0;
      S_D0:   state_nxt = S_D1;
      S_D1:   state_nxt = S_D2;
      S_D2:   state_nxt = sum_w[64] ? S_CMP : S_SQ;
      S_SQ:   if (sqrt_sts.done) state_nxt = S_CMP;
      S_CMP: begin
        if (idx_r == IDX_END) begin
          state_nxt = S_FIN;
        end else if (idx_r == IDX_LAST) begin
          state_nxt = S_E0;
        end else begin
          state_nxt = S_V0;
        end
      end
      S_FIN:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      center_x_r  <= '0;
      center_y_r  <= '0;
      radius_x_r  <= '0;
      radius_y_r  <= '0;
      cos_rot_r   <= ONE_Q30;
      sin_rot_r   <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_addr)
          REG_CENTER_X: center_x_r <= cfg_wdata;
          REG_CENTER_Y: center_y_r <= cfg_wdata;
          REG_RADIUS_X: radius_x_r <= cfg_wdata[30:0];
          REG_RADIUS_Y: radius_y_r <= cfg_wdata[30:0];
          REG_COS_ROT:  cos_rot_r  <= cfg_wdata;
          REG_SIN_ROT:  sin_rot_r  <= cfg_wdata;
          default: ;
        endcase
      end

      // A new result refills the output register in the cycle it empties.
      if ((state_r == S_FIN) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: if (in_xfer) begin
          px_r   <= in_tdata[31:0];
          py_r   <= in_tdata[63:32];
          idx_r  <= '0;
          best_r <= 32'hFFFFFFFF;
        end
        S_V1: lx_r <= 33'(rnd30(p64));
        S_V2: ly_r <= 33'(rnd30(p64));
        S_V3: acc_r <= p64;
        S_V4: bx_r <= sat32(64'(center_x_r) + rnd30(acc_r - p64));
        S_V5: acc_r <= p64;
        S_V6: begin
          by_r <= sat32(64'(center_y_r) + rnd30(acc_r + p64));
          // The first vertex opens the polygon and also closes it.
          if (idx_r == '0) begin
            ax_r  <= bx_r;
            ay_r  <= sat32(64'(center_y_r) + rnd30(acc_r + p64));
            fx_r  <= bx_r;
            fy_r  <= sat32(64'(center_y_r) + rnd30(acc_r + p64));
            idx_r <= idx_r + 1'b1;
          end
        end
        S_E0: begin
          sx_r  <= sx_w;
          sy_r  <= sy_w;
          sxs_r <= trunc3(sx_w);
          sys_r <= trunc3(sy_w);
          dxs_r <= trunc3(dx_w);
          dys_r <= trunc3(dy_w);
        end
        S_E2: acc_r <= p64;
        S_E3: len_r <= acc_r + p64;
        S_E4: acc_r <= p64;
        S_E5: begin
          // A degenerate edge measures to its start vertex.
          if (len_zero) begin
            ex_r <= dx_w;
            ey_r <= dy_w;
          end else if (dot_full) begin
            t_r <= 31'h40000000;
          end else if (!dot_pos) begin
            t_r <= '0;
          end
        end
        S_DIV: if (div_sts.done) t_r <= {1'b0, quo};
        S_P1: ex_r <= ex_w[35:0];
        S_P2: ey_r <= ey_w[35:0];
        S_D1: acc_r <= p64;
        S_D2: if (sum_w[64]) d_r <= 32'hFFFFFFFF;
        S_SQ: if (sqrt_sts.done) d_r <= root;
        S_CMP: begin
          if (d_r < best_r) best_r <= d_r;
          if (idx_r != IDX_END) begin
            ax_r  <= bx_r;
            ay_r  <= by_r;
            idx_r <= idx_r + 1'b1;
            if (idx_r == IDX_LAST) begin
              bx_r <= fx_r;
              by_r <= fy_r;
            end
          end
        end
        S_FIN: if (!out_valid_r || out_tready) begin
          out_data_r <= best_r;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> tb/tb_ellipse_polygon_point_distance_unit.sv
`timescale 1ns / 100ps

module tb_ellipse_polygon_point_distance_unit;
  import epd_pkg::*;

  localparam int NUM_SAMPLES = 64;

  // Register indexes with no register behind them; writes there must be ignored.
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  localparam logic [31:0] DIST_SATURATED = 32'hFFFFFFFF;

  typedef struct packed {
    logic signed [31:0] point_y;
    logic signed [31:0] point_x;
  } query_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;    // [31:0] point_x, [63:32] point_y
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // [31:0] distance
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  ellipse_polygon_point_distance_unit #(
    .SAMPLES(NUM_SAMPLES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the ellipse registers, kept in step with every write.
  longint shadow_cx, shadow_cy, shadow_rx, shadow_ry, shadow_cos, shadow_sin;

  // Unit-circle samples of the perimeter in Q2.30, built once at start.
  longint circle_cos [NUM_SAMPLES];
  longint circle_sin [NUM_SAMPLES];

  query_t      pending_queries[$];
  logic [31:0] expected_dist[$];

  int  errors;
  int  queries_sent;
  int  results_seen;
  int  configs_used;

  // Handshake bookkeeping shared between the rising-edge monitor and the
  // falling-edge drivers.
  bit  in_fired;
  bit  out_fired;
  bit  no_idle;
  int  in_gap;
  int  out_stall;

  // Round a Q30 scaled product to an integer, ties away from zero.
  function automatic longint round_q30(input longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << 29)) >> 30;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Drop three LSBs, truncating toward zero.
  function automatic longint coarse3(input longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = m >> 3;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Fill the sample table: octant folding plus a seven-term series in Q2.30.
  task automatic build_circle();
    longint unsigned turn, frac;
    longint x, x2, ts, tc, ss, cc, ks, kc;
    int     quad;
    bit     swap;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      turn = ((longint'(i) << 32) / NUM_SAMPLES) & 64'hFFFFFFFF;
      quad = int'(turn >> 30);
      frac = turn & 64'h3FFFFFFF;
      swap = frac > 64'h20000000;
      if (swap) frac = 64'h40000000 - frac;
      x  = longint'((frac * 64'd3373259426) >> 31);
      x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
      ts = x;
      tc = 64'sd1 <<< 30;
      ss = ts;
      cc = tc;
      for (int k = 1; k <= 6; k++) begin
        ts = ((ts * x2) >>> 30) / ((2 * k) * (2 * k + 1));
        tc = ((tc * x2) >>> 30) / ((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          ss -= ts;
          cc -= tc;
        end else begin
          ss += ts;
          cc += tc;
        end
      end
      ks = swap ? cc : ss;
      kc = swap ? ss : cc;
      case (quad)
        0: begin circle_cos[i] = kc;  circle_sin[i] = ks;  end
        1: begin circle_cos[i] = -ks; circle_sin[i] = kc;  end
        2: begin circle_cos[i] = -kc; circle_sin[i] = -ks; end
        default: begin circle_cos[i] = ks; circle_sin[i] = -kc; end
      endcase
    end
  endtask

  // Euclidean length of an offset, Q16.16, rounded and saturating.
  function automatic logic [31:0] offset_length(input longint ex, input longint ey);
    longint unsigned mx, my, sq_x, sum, rest, root, bitv;
    mx   = (ex < 0) ? longint'(-ex) : ex;
    my   = (ey < 0) ? longint'(-ey) : ey;
    sq_x = mx * mx;
    sum  = sq_x + my * my;
    if (sum < sq_x) return DIST_SATURATED;
    rest = sum;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rest) bitv >>= 2;
    while (bitv != 0) begin
      if (rest >= root + bitv) begin
        rest -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (rest > root) root++;
    return (root > 64'hFFFFFFFF) ? DIST_SATURATED : root[31:0];
  endfunction

  function automatic logic [31:0] edge_distance(input longint px, input longint py,
                                               input longint ax, input longint ay,
                                               input longint bx, input longint by);
    longint sx, sy, sxc, syc, dxc, dyc, len, dot, t, rem;
    sx  = bx - ax;
    sy  = by - ay;
    sxc = coarse3(sx);
    syc = coarse3(sy);
    dxc = coarse3(px - ax);
    dyc = coarse3(py - ay);
    len = sxc * sxc + syc * syc;
    t   = 0;
    if (len == 0) return offset_length(px - ax, py - ay);
    dot = dxc * sxc + dyc * syc;
    if (dot >= len) begin
      t = 64'sd1 <<< 30;
    end else if (dot > 0) begin
      rem = dot;
      for (int k = 0; k < 30; k++) begin
        rem = rem <<< 1;
        t   = t <<< 1;
        if (rem >= len) begin
          rem -= len;
          t |= 1;
        end
      end
    end
    return offset_length(px - (ax + round_q30(sx * t)), py - (ay + round_q30(sy * t)));
  endfunction

  // Minimum distance from the query point to the sampled, rotated ellipse.
  function automatic logic [31:0] ellipse_distance(input query_t q);
    longint c, s, lx, ly, px, py;
    longint vx [NUM_SAMPLES + 1];
    longint vy [NUM_SAMPLES + 1];
    logic [31:0] best, d;
    c  = clip(shadow_cos, -(64'sd1 <<< 30), 64'sd1 <<< 30);
    s  = clip(shadow_sin, -(64'sd1 <<< 30), 64'sd1 <<< 30);
    px = q.point_x;
    py = q.point_y;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      lx = round_q30(shadow_rx * circle_cos[i]);
      ly = round_q30(shadow_ry * circle_sin[i]);
      vx[i] = clip(shadow_cx + round_q30(lx * c - ly * s), -64'sd2147483648, 64'sd2147483647);
      vy[i] = clip(shadow_cy + round_q30(lx * s + ly * c), -64'sd2147483648, 64'sd2147483647);
    end
    vx[NUM_SAMPLES] = vx[0];
    vy[NUM_SAMPLES] = vy[0];
    best = DIST_SATURATED;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      d = edge_distance(px, py, vx[i], vy[i], vx[i + 1], vy[i + 1]);
      if (d < best) best = d;
    end
    return best;
  endfunction

  // Rising edge: record transfers on both channels. An accepted query gets
  // its expected distance right away, from the registers in force now.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_dist.push_back(ellipse_distance(query_t'(in_tdata)));
        queries_sent++;
        in_fired = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        out_fired = 1'b1;
        if (expected_dist.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $realtime, out_tdata);
          errors++;
        end else if (out_tdata !== expected_dist[0]) begin
          $display("%0t: distance mismatch, expected %h, actual %h",
                   $realtime, expected_dist[0], out_tdata);
          errors++;
          void'(expected_dist.pop_front());
        end else begin
          void'(expected_dist.pop_front());
        end
      end
    end
  end

  // Falling edge: query sender. After each transfer it waits a random
  // number of cycles before offering the next point, unless idling is off.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_gap    = 0;
    end else begin
      if (in_fired) begin
        in_fired = 1'b0;
        in_gap   = no_idle ? 0 : $urandom_range(0, 6);
        if (in_gap == 0 && pending_queries.size() > 0) begin
          in_tdata <= pending_queries.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end else if (!in_tvalid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_queries.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_queries.pop_front();
        end
      end
    end
  end

  // Falling edge: result receiver. After each transfer it draws how many
  // cycles the next offered result is held off before it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  = 0;
    end else begin
      if (out_fired) begin
        out_fired = 1'b0;
        out_stall = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (out_stall > 0) begin
        out_tready <= 1'b0;
        if (out_tvalid) out_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Register write, issued only while no query is in flight.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      REG_CENTER_X: shadow_cx  = longint'($signed(value));
      REG_CENTER_Y: shadow_cy  = longint'($signed(value));
      REG_RADIUS_X: shadow_rx  = longint'(value[30:0]);
      REG_RADIUS_Y: shadow_ry  = longint'(value[30:0]);
      REG_COS_ROT:  shadow_cos = longint'($signed(value));
      REG_SIN_ROT:  shadow_sin = longint'($signed(value));
      default: ;
    endcase
  endtask

  task automatic set_ellipse(input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] rx, input logic [31:0] ry,
                             input logic [31:0] c, input logic [31:0] s);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIUS_X, rx);
    write_reg(REG_RADIUS_Y, ry);
    write_reg(REG_COS_ROT, c);
    write_reg(REG_SIN_ROT, s);
    configs_used++;
  endtask

  task automatic queue_point(input logic [31:0] x, input logic [31:0] y);
    query_t q;
    q.point_x = x;
    q.point_y = y;
    pending_queries.push_back(q);
  endtask

  // Waits until every queued point has been taken and answered.
  task automatic drain();
    wait (pending_queries.size() == 0 && !in_tvalid && expected_dist.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // Random points: most land at a random scale around the center, so the
  // nearest edge varies; the rest span the whole coordinate range.
  task automatic queue_random(input int count);
    logic [31:0] x, y;
    int          scale;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        x = $urandom;
        y = $urandom;
      end else begin
        scale = $urandom_range(0, 31);
        x = 32'(shadow_cx + (longint'($signed($urandom)) >>> scale));
        y = 32'(shadow_cy + (longint'($signed($urandom)) >>> scale));
      end
      queue_point(x, y);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    errors       = 0;
    queries_sent = 0;
    results_seen = 0;
    configs_used = 1;
    no_idle      = 1'b0;
    in_fired     = 1'b0;
    out_fired    = 1'b0;
    shadow_cx  = 0;
    shadow_cy  = 0;
    shadow_rx  = 0;
    shadow_ry  = 0;
    shadow_cos = 64'sd1 <<< 30;
    shadow_sin = 0;
    build_circle();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset values: both radii are zero, so every answer is the distance to
    // the origin. Corner points give the largest offsets.
    queue_point(32'h0, 32'h0);
    queue_point(32'h0001_0000, 32'h0);
    queue_point(32'hFFFF_0000, 32'h0002_8000);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_point(32'h8000_0000, 32'h8000_0000);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000);
    queue_point(32'h00FF_FFFF, 32'h0);
    queue_point(32'h0000_0001, 32'hFFFF_FFFF);
    drain();

    // A tilted 10 x 4 ellipse, rotated by thirty degrees. Points on the
    // center, near a vertex and far out along each axis.
    set_ellipse(32'h0001_8000, 32'hFFFE_0000, 32'h000A_0000, 32'h0004_0000,
                32'd929887697, 32'd536870912);
    queue_point(32'h0001_8000, 32'hFFFE_0000);
    queue_point(32'h0009_E000, 32'h0003_0000);
    queue_point(32'h0100_0000, 32'hFFFE_0000);
    queue_point(32'h0001_8000, 32'hF000_0000);
    queue_random(50);
    drain();

    // Extremes: the center in the corner, the largest radii and rotation
    // values out of range, so vertices and the rotation both saturate.
    set_ellipse(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000);
    queue_random(40);
    drain();

    // Tiny radii: many edges are shorter than eight LSBs per axis. The
    // sender pauses halfway until every result is back.
    no_idle = 1'b1;
    set_ellipse($urandom, $urandom, 32'd20, 32'd5, 32'hC000_0000, 32'h4000_0000);
    queue_random(25);
    drain();
    no_idle = 1'b0;
    queue_random(25);
    drain();

    // Random shapes, with full-width data so the ignored top radius bit and
    // independent, possibly out-of-range, rotation terms are covered.
    for (int k = 0; k < 3; k++) begin
      set_ellipse($urandom, $urandom, $urandom >> $urandom_range(0, 14),
                  $urandom >> $urandom_range(0, 14), $urandom, $urandom);
      queue_random(35);
      drain();
    end

    // Writes to the spare indexes must leave the registers alone.
    set_ellipse(32'hFFF0_0000, 32'h0010_0000, 32'h0003_0000, 32'h0000_0000,
                32'h0000_0000, 32'hC000_0000);
    write_reg(REG_SPARE_6, $urandom);
    write_reg(REG_SPARE_7, $urandom);
    queue_random(30);
    drain();

    $display("Ran %0d queries against %0d ellipse setups, %0d distances checked.",
             queries_sent, configs_used, results_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // This bound is several times the slowest legal run.
  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
